// ===== rtl/first_match_substring_search_unit_assert.svh =====
// Assertion helpers shared by the substring search blocks.
// Both expect i_clk and i_rst_n to be visible where they are used.
`ifndef FIRST_MATCH_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define FIRST_MATCH_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication
`define FMSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FMSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fmss_pkg.sv =====
// ----------------------------------------------------------------------------
// fmss_pkg
// Shared constants and types of the first-match substring search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fmss_pkg;

    // Default sizes
    localparam int P_MAX_PATTERN = 64;
    localparam int P_MAX_TEXT    = 65536;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 7;
    localparam int POS_W  = 16;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Item function codes
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // One compare outcome handed to the back end
    typedef struct packed {
        logic             hit;
        logic             last;
        logic [POS_W-1:0] pos;
    } t_job;

    typedef struct packed {
        logic vld;
        t_job job;
    } t_job_push;

endpackage

`default_nettype wire

// ===== rtl/fmss_ram.sv =====
// ----------------------------------------------------------------------------
// fmss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/fmss_front.sv =====
// ----------------------------------------------------------------------------
// fmss_front
// Accepts pattern and text items, keeps the pattern and the text window,
// compares all lanes in parallel and hands one job per relevant text byte on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_match_substring_search_unit_assert.svh"

module fmss_front
    import fmss_pkg::*;
#(
    parameter int MAX_PATTERN = P_MAX_PATTERN,
    parameter int MAX_TEXT    = P_MAX_TEXT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic              i_func,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_end_of_text,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_pattern_length,
    input  wire logic [QCNT_W-1:0] i_q_cnt,
    output t_job_push              o_push
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int AW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W = $clog2(MAX_TEXT + 1);

    // Configuration and counters
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_cnt;

    // Text window (entry 0 newest) and pattern copy aligned to window lanes
    logic [BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [BYTE_W-1:0] r_pal [MAX_PATTERN];

    // Rebuild sweep of the aligned copy
    logic              r_swp_act;
    logic [LEN_W-1:0]  r_swp_idx;
    logic              r_swp_wr;
    logic [AW-1:0]     r_swp_lane;

    // Compare stage
    logic                   r_s1_vld;
    logic [MAX_PATTERN-1:0] r_s1_eq;
    logic                   r_s1_chk;
    logic                   r_s1_last;
    logic [POS_W-1:0]       r_s1_pos;

    logic                   accept;
    logic                   pat_acc;
    logic                   txt_acc;
    logic                   pat_wr;
    logic                   pal_wr;
    logic [AW-1:0]          pal_lane;
    logic                   swp_rd;
    logic [BYTE_W-1:0]      ram_rd_data;
    logic [LEN_W-1:0]       len_eff;
    logic [31:0]            cfg_ext;
    logic [QCNT_W:0]        inflight;
    logic                   in_range;
    logic [CNT_W-1:0]       cnt_p1;
    logic                   chk;
    logic [31:0]            pos_diff;
    logic [MAX_PATTERN-1:0] lane_eq;

    // Clamp the written length into 1..MAX_PATTERN
    always_comb begin
        cfg_ext = 32'(i_cfg_pattern_length);
        if (cfg_ext == 32'd0) begin
            len_eff = LEN_W'(1);
        end else if (cfg_ext > 32'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = LEN_W'(cfg_ext);
        end
    end

    assign o_cfg_ready = 1'b1;

    // Hold input while rebuilding or while the job queue has no room
    assign inflight = {1'b0, i_q_cnt} + (QCNT_W + 1)'(r_s1_vld);
    assign o_full   = r_swp_act || r_swp_wr || (inflight >= (QCNT_W + 1)'(Q_DEPTH));

    assign accept  = i_push && !o_full;
    assign pat_acc = accept && (i_func == FUNC_PATTERN);
    assign txt_acc = accept && (i_func == FUNC_TEXT);

    // Pattern load: store in RAM and drop into its window lane when in use
    assign pat_wr   = pat_acc && (32'(r_fill) < 32'(MAX_PATTERN));
    assign pal_wr   = pat_wr && (r_fill < r_len);
    assign pal_lane = AW'(r_len - r_fill - LEN_W'(1));

    assign swp_rd = r_swp_act && (r_swp_idx < r_len);

    fmss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_pat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pat_wr),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_data_byte),
        .i_rd_en   (swp_rd),
        .i_rd_addr (r_swp_idx[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Text position bookkeeping
    assign in_range = r_cnt < CNT_W'(MAX_TEXT);
    assign cnt_p1   = r_cnt + CNT_W'(1);
    assign chk      = in_range && (32'(cnt_p1) >= 32'(r_len));
    assign pos_diff = 32'(cnt_p1) - 32'(r_len);

    // Lane compare against the window as it stands after this byte
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_lane
        logic [BYTE_W-1:0] lane_byte;
        if (k == 0) begin : g_head
            assign lane_byte = i_data_byte;
        end else begin : g_tail
            assign lane_byte = r_win[k-1];
        end
        assign lane_eq[k] = (32'(k) >= 32'(r_len)) || (lane_byte == r_pal[k]);
    end

    // Length, fill index, text count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(1);
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= len_eff;
            end
            if (pat_wr) begin
                r_fill <= r_fill + LEN_W'(1);
            end else if (txt_acc && i_end_of_text) begin
                r_fill <= '0;
            end
            if (txt_acc) begin
                if (i_end_of_text) begin
                    r_cnt <= '0;
                end else if (in_range) begin
                    r_cnt <= cnt_p1;
                end
            end
        end
    end

    // Shift the window, clear it at the end of a search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
        end else if (txt_acc) begin
            if (i_end_of_text) begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    r_win[i] <= '0;
                end
            end else if (in_range) begin
                r_win[0] <= i_data_byte;
                for (int i = 1; i < MAX_PATTERN; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

    // Rebuild sweep: one RAM read per cycle after a length write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp_act <= 1'b0;
            r_swp_idx <= '0;
            r_swp_wr  <= 1'b0;
        end else if (i_cfg_valid) begin
            r_swp_act <= 1'b1;
            r_swp_idx <= '0;
            r_swp_wr  <= 1'b0;
        end else if (r_swp_act) begin
            r_swp_wr <= swp_rd;
            if (swp_rd) begin
                r_swp_idx <= r_swp_idx + LEN_W'(1);
            end else begin
                r_swp_act <= 1'b0;
            end
        end else begin
            r_swp_wr <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (swp_rd) begin
            r_swp_lane <= AW'(r_len - r_swp_idx - LEN_W'(1));
        end
    end

    // Aligned pattern copy
    always_ff @(posedge i_clk) begin
        if (r_swp_wr) begin
            r_pal[r_swp_lane] <= ram_rd_data;
        end else if (pal_wr) begin
            r_pal[pal_lane] <= i_data_byte;
        end
    end

    // Compare stage: keep a job only where it can lead to a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= txt_acc && (chk || i_end_of_text);
        end
    end

    always_ff @(posedge i_clk) begin
        if (txt_acc) begin
            r_s1_eq   <= lane_eq;
            r_s1_chk  <= chk;
            r_s1_last <= i_end_of_text;
            r_s1_pos  <= pos_diff[POS_W-1:0];
        end
    end

    // Reduce the lanes and push the job
    always_comb begin
        o_push.vld      = r_s1_vld;
        o_push.job.hit  = r_s1_chk && (&r_s1_eq);
        o_push.job.last = r_s1_last;
        o_push.job.pos  = r_s1_pos;
    end

    `FMSS_ASSERT_IMPLY(a_swp_holds_input, r_swp_act, o_full,
        "input taken while the aligned pattern is rebuilt")
    `FMSS_ASSERT_NEXT(a_last_resets_search, txt_acc && i_end_of_text,
        (r_cnt == '0) && (r_fill == '0) && (r_win[0] == '0),
        "search state not cleared after the final text byte")
    `FMSS_ASSERT_IMPLY(a_fill_bound, 1'b1, 32'(r_fill) <= 32'(MAX_PATTERN),
        "pattern fill index past the pattern store")

endmodule

`default_nettype wire

// ===== rtl/fmss_back.sv =====
// ----------------------------------------------------------------------------
// fmss_back
// Job queue and result stage: tracks the first match of the running search
// and emits at most one result per search into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_match_substring_search_unit_assert.svh"

module fmss_back
    import fmss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_job_push         i_push,
    output logic [QCNT_W-1:0]      o_q_cnt,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic                   o_found,
    output logic [POS_W-1:0]       o_position
);

    // Job queue
    t_job              r_q [Q_DEPTH];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QCNT_W-1:0] r_qcnt;

    // Search and output state
    logic              r_mr;
    logic              r_out_vld;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_pos;

    t_job              head;
    logic              q_vld;
    logic              needs_out;
    logic              out_free;
    logic              deq;

    assign head      = r_q[r_rp];
    assign q_vld     = r_qcnt != '0;
    assign needs_out = !r_mr && (head.hit || head.last);
    assign out_free  = !r_out_vld || i_pop;
    assign deq       = q_vld && (!needs_out || out_free);

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (i_push.vld) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (deq) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_qcnt <= r_qcnt + QCNT_W'(i_push.vld) - QCNT_W'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_q[r_wp] <= i_push.job;
        end
    end

    // Match flag: set on first hit, drop at the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mr <= 1'b0;
        end else if (deq) begin
            r_mr <= head.last ? 1'b0 : (r_mr || head.hit);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (deq && needs_out) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deq && needs_out) begin
            r_out_found <= head.hit;
            r_out_pos   <= head.hit ? head.pos : '0;
        end
    end

    assign o_q_cnt    = r_qcnt;
    assign o_empty    = !r_out_vld;
    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

    `FMSS_ASSERT_IMPLY(a_q_no_overflow, i_push.vld, r_qcnt < QCNT_W'(Q_DEPTH),
        "job pushed into a full queue")
    `FMSS_ASSERT_IMPLY(a_miss_pos_zero, r_out_vld && !r_out_found, r_out_pos == '0,
        "no-match result carries a nonzero position")
    `FMSS_ASSERT_NEXT(a_last_clears_match, deq && head.last, !r_mr,
        "match flag survives the end of a search")

endmodule

`default_nettype wire

// ===== rtl/first_match_substring_search_unit.sv =====
// ----------------------------------------------------------------------------
// first_match_substring_search_unit
// Streams text bytes against a loaded pattern and reports the first match.
// ----------------------------------------------------------------------------
// Pattern bytes (func 0) load the pattern store; text bytes (func 1) shift
// into a window compared with the pattern on every byte in parallel lanes.
// The unit takes one item per cycle while full is low. A result (found and
// start position, or not found with position 0 on the final byte) passes
// the lane compare register, the four-entry job queue and the output
// register on its way to the output. full also rises when the job queue
// backs up behind an unpopped result. A pattern_length write starts a
// rebuild of the lane-aligned pattern copy from the pattern RAM, one entry
// per cycle through its single read port; input stays full while the
// copy is rebuilt over the clamped length (0 counts as 1, anything above
// MAX_PATTERN as MAX_PATTERN).
// ----------------------------------------------------------------------------
`default_nettype none

module first_match_substring_search_unit
    import fmss_pkg::*;
#(
    parameter int MAX_PATTERN = P_MAX_PATTERN,
    parameter int MAX_TEXT    = P_MAX_TEXT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              i_func,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_end_of_text,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   o_found,
    output logic [POS_W-1:0]       o_position,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_pattern_length
);

    t_job_push         job_push;
    logic [QCNT_W-1:0] q_cnt;

    fmss_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_push               (push),
        .o_full               (full),
        .i_func               (i_func),
        .i_data_byte          (i_data_byte),
        .i_end_of_text        (i_end_of_text),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_pattern_length (i_cfg_pattern_length),
        .i_q_cnt              (q_cnt),
        .o_push               (job_push)
    );

    fmss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (job_push),
        .o_q_cnt    (q_cnt),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_found    (o_found),
        .o_position (o_position)
    );

endmodule

`default_nettype wire

// ===== tb/first_match_substring_search_unit_test.sv =====
// ----------------------------------------------------------------------------
// first_match_substring_search_unit_test
// Self-checking bench for the first-match substring search unit.
// ----------------------------------------------------------------------------
// Feeds pattern and text bytes through the push/full side in random bursts,
// drains results through empty/pop with its own stall pattern, and checks
// every result against an internal search model. Pattern length is rewritten
// between phases while the unit is idle, covering 0, 127 and the sizes
// in between.
// ----------------------------------------------------------------------------
`default_nettype none

module first_match_substring_search_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fmss_pkg::*;

    localparam int MAX_PAT        = P_MAX_PATTERN;
    localparam int MAX_TXT        = P_MAX_TEXT;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data;
        logic              eot;
    } t_stream_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_report;

    // Clock, reset and block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic              i_func = 1'b0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_end_of_text = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_found;
    logic [POS_W-1:0]  o_position;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_pattern_length = '0;

    // Items waiting to be pushed and reports waiting to be popped
    t_stream_item   byte_items[$];
    t_search_report expected_reports[$];

    // Search model state
    logic [BYTE_W-1:0] pat_mem [MAX_PAT];
    logic [BYTE_W-1:0] text_win [MAX_PAT];
    int unsigned       fill_ptr;
    int unsigned       text_pos;
    bit                match_done;
    logic [CFG_W-1:0]  length_reg;

    // Stimulus-side mirror of what the pattern store holds
    logic [BYTE_W-1:0] gen_pat [MAX_PAT];
    bit [MAX_PAT-1:0]  gen_written;
    int unsigned       gen_fill;
    int unsigned       gen_len;
    logic [BYTE_W-1:0] alpha [4];
    int unsigned       alpha_n;
    bit                full_range;

    // Run statistics
    int unsigned queued;
    int unsigned random_items;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_hits;
    int unsigned n_searches;
    int unsigned n_cfg;
    int unsigned err_count;
    int unsigned idle_cycles;

    // Sender and receiver pacing
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned drain_mode;
    int unsigned mode_left;
    int unsigned drain_tick;

    first_match_substring_search_unit DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_func               (i_func),
        .i_data_byte          (i_data_byte),
        .i_end_of_text        (i_end_of_text),
        .empty                (empty),
        .pop                  (pop),
        .o_found              (o_found),
        .o_position           (o_position),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_pattern_length (i_cfg_pattern_length)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp the length register to the window size in use
    function automatic int unsigned active_len(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_PAT) return MAX_PAT;
        return 32'(v);
    endfunction

    // Advance the search model by one accepted item
    task automatic predict_search(input t_stream_item it);
        int unsigned    len;
        bit             hit;
        bit             made;
        t_search_report rep;
        made = 1'b0;
        if (it.func == FUNC_PATTERN) begin
            if (fill_ptr < MAX_PAT) begin
                pat_mem[fill_ptr] = it.data;
                fill_ptr++;
            end
        end else begin
            if (!match_done) begin
                if (text_pos < MAX_TXT) begin
                    len = active_len(length_reg);
                    for (int k = MAX_PAT - 1; k > 0; k--) text_win[k] = text_win[k-1];
                    text_win[0] = it.data;
                    text_pos++;
                    if (text_pos >= len) begin
                        hit = 1'b1;
                        for (int k = 0; k < len; k++) begin
                            if (text_win[k] != pat_mem[len-1-k]) hit = 1'b0;
                        end
                        if (hit) begin
                            rep.found        = 1'b1;
                            rep.position     = POS_W'(text_pos - len);
                            expected_reports = {expected_reports, rep};
                            match_done       = 1'b1;
                            made             = 1'b1;
                        end
                    end
                end
                if (it.eot && !made) begin
                    rep.found        = 1'b0;
                    rep.position     = '0;
                    expected_reports = {expected_reports, rep};
                end
            end
            // End of search: clear everything but the pattern store
            if (it.eot) begin
                for (int k = 0; k < MAX_PAT; k++) text_win[k] = '0;
                text_pos   = 0;
                match_done = 1'b0;
                fill_ptr   = 0;
            end
        end
    endtask

    // Check popped results, run the model on pushed items, watch for hangs
    always @(posedge i_clk) begin : check_side
        t_search_report exp;
        t_stream_item   it;
        bit             progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (pop && !empty) begin
                progress = 1'b1;
                n_results++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: found %0d position %0d", o_found, o_position);
                    err_count++;
                end else begin
                    exp = expected_reports.pop_front();
                    if (o_found !== exp.found) begin
                        $error("found: expected %0d, actual %0d", exp.found, o_found);
                        err_count++;
                    end
                    if (o_position !== exp.position) begin
                        $error("position: expected %0d, actual %0d", exp.position, o_position);
                        err_count++;
                    end
                    if (exp.found) n_hits++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress   = 1'b1;
                length_reg = i_cfg_pattern_length;
                n_cfg++;
            end
            if (push && !full) begin
                progress = 1'b1;
                it.func  = i_func;
                it.data  = i_data_byte;
                it.eot   = i_end_of_text;
                void'(byte_items.pop_front());
                predict_search(it);
                n_items++;
                if (it.func == FUNC_TEXT && it.eot) n_searches++;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("run stalled after %0d items and %0d results", n_items, n_results);
                $display("first_match_substring_search_unit_test: errors");
                $finish;
            end
        end
    end

    // Push items in bursts with random gaps
    always @(negedge i_clk) begin : feed_side
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (gap_left > 0) begin
            push <= 1'b0;
            gap_left--;
        end else if (byte_items.size() != 0) begin
            push          <= 1'b1;
            i_func        <= byte_items[0].func;
            i_data_byte   <= byte_items[0].data;
            i_end_of_text <= byte_items[0].eot;
            if (burst_left > 1) begin
                burst_left--;
            end else if ($urandom_range(0, 9) < 2) begin
                // long stretch with no gaps
                burst_left = $urandom_range(64, 200);
                gap_left   = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap_left   = $urandom_range(1, 6);
            end
        end else begin
            push <= 1'b0;
        end
    end

    // Pop results, switching between stall patterns now and then
    always @(negedge i_clk) begin : drain_side
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                drain_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            drain_tick++;
            case (drain_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 3) != 0);
                2: pop <= ($urandom_range(0, 1) == 1);
                default: pop <= ((drain_tick % 8) < 5);
            endcase
        end
    end

    // Append one item and track what the pattern store will hold
    task automatic queue_item(input logic f, input logic [BYTE_W-1:0] d, input logic e);
        t_stream_item it;
        it.func = f;
        it.data = d;
        it.eot  = e;
        byte_items = {byte_items, it};
        queued++;
        if (f == FUNC_PATTERN) begin
            if (gen_fill < MAX_PAT) begin
                gen_pat[gen_fill]     = d;
                gen_written[gen_fill] = 1'b1;
                gen_fill++;
            end
        end else if (e) begin
            gen_fill = 0;
        end
    endtask

    // Text is only legal once every active pattern entry has been written
    function automatic bit text_ok();
        for (int k = 0; k < gen_len; k++) begin
            if (!gen_written[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] next_symbol();
        if (full_range) return BYTE_W'($urandom_range(0, 255));
        return alpha[$urandom_range(0, alpha_n - 1)];
    endfunction

    // One search: load a pattern, stream text over a small alphabet or the full byte range, end it
    task automatic build_search();
        int unsigned       plen;
        int unsigned       tlen;
        int unsigned       plant_at;
        int unsigned       r;
        bit                plant;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 9);
        full_range = (r == 9);
        if (r < 2) begin
            alpha_n  = 2;
            alpha[0] = 8'h00;
            alpha[1] = 8'hFF;
        end else begin
            alpha_n = $urandom_range(1, 3);
            for (int k = 0; k < alpha_n; k++) alpha[k] = BYTE_W'($urandom_range(0, 255));
        end
        // full reload, overflowing reload, or partial reload over old bytes
        r = $urandom_range(0, 19);
        if (r < 14 || !text_ok()) plen = gen_len;
        else if (r < 17) plen = gen_len + $urandom_range(1, 8);
        else plen = $urandom_range(0, gen_len - 1);
        for (int k = 0; k < plen; k++) begin
            queue_item(FUNC_PATTERN, next_symbol(), $urandom_range(0, 7) == 0);
        end
        if ($urandom_range(0, 6) == 0) tlen = $urandom_range(1, gen_len);
        else tlen = gen_len + $urandom_range(0, 24);
        plant    = (tlen >= gen_len) && ($urandom_range(0, 1) == 1);
        plant_at = plant ? $urandom_range(0, tlen - gen_len) : 0;
        for (int k = 0; k < tlen; k++) begin
            // stray pattern byte in the middle of the text
            if ($urandom_range(0, 59) == 0) begin
                queue_item(FUNC_PATTERN, next_symbol(), $urandom_range(0, 1) == 1);
            end
            if (plant && k >= plant_at && k < plant_at + gen_len) b = gen_pat[k - plant_at];
            else b = next_symbol();
            queue_item(FUNC_TEXT, b, k == tlen - 1);
        end
    endtask

    // Hold until every item is in and every result is out, then let it settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_items.size() != 0 || expected_reports.size() != 0 || push);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] v);
        i_cfg_pattern_length <= v;
        i_cfg_valid          <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_len = active_len(v);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] v);
        int unsigned start;
        wait_idle();
        write_length(v);
        start = queued;
        do build_search();
        while (queued - start < PHASE_ITEMS);
        random_items += queued - start;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] plan [10];
        int unsigned      r;
        plan       = '{7'd0, 7'd127, 7'd64, 7'd65, 7'd1, 7'd2, 7'd3, 7'd85, 7'd42, 7'd8};
        length_reg = 7'd1;
        gen_len    = 1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-byte pattern at the reset length
        queue_item(FUNC_PATTERN, 8'h00, 1'b0);
        queue_item(FUNC_TEXT,    8'hFF, 1'b0);
        queue_item(FUNC_TEXT,    8'h00, 1'b1);   // match at offset 1 on the final byte
        queue_item(FUNC_PATTERN, 8'hFF, 1'b1);   // end flag on a pattern byte is ignored
        queue_item(FUNC_TEXT,    8'hFF, 1'b1);   // match on final byte is the only result
        queue_item(FUNC_PATTERN, 8'h80, 1'b0);
        queue_item(FUNC_TEXT,    8'h01, 1'b0);
        queue_item(FUNC_TEXT,    8'h7F, 1'b1);   // no match
        queue_item(FUNC_PATTERN, 8'h3C, 1'b0);
        queue_item(FUNC_TEXT,    8'h3C, 1'b0);   // match at offset 0
        queue_item(FUNC_TEXT,    8'h3C, 1'b0);   // ignored after the match
        queue_item(FUNC_TEXT,    8'h00, 1'b1);   // final byte after a match: nothing
        queue_item(FUNC_TEXT,    8'h3C, 1'b1);   // pattern store survives the search end

        // Directed: four-byte pattern, text too short, then an exact fit
        wait_idle();
        write_length(7'd4);
        queue_item(FUNC_PATTERN, 8'hAA, 1'b0);
        queue_item(FUNC_PATTERN, 8'hBB, 1'b0);
        queue_item(FUNC_PATTERN, 8'hCC, 1'b0);
        queue_item(FUNC_PATTERN, 8'hDD, 1'b0);
        queue_item(FUNC_TEXT,    8'hAA, 1'b0);
        queue_item(FUNC_TEXT,    8'hBB, 1'b0);
        queue_item(FUNC_TEXT,    8'hCC, 1'b1);
        queue_item(FUNC_TEXT,    8'hAA, 1'b0);
        queue_item(FUNC_TEXT,    8'hBB, 1'b0);
        queue_item(FUNC_TEXT,    8'hCC, 1'b0);
        queue_item(FUNC_TEXT,    8'hDD, 1'b1);

        // Random searches over a fixed set of lengths, then random lengths
        foreach (plan[i]) run_phase(plan[i]);
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 6) run_phase(CFG_W'($urandom_range(1, 8)));
            else if (r < 8) run_phase(CFG_W'($urandom_range(9, 64)));
            else run_phase(CFG_W'($urandom_range(0, 127)));
        end

        wait_idle();
        if (expected_reports.size() != 0) begin
            $error("%0d results never arrived", expected_reports.size());
            err_count++;
        end
        $display("run covered %0d items in %0d searches over %0d length writes",
                 n_items, n_searches, n_cfg);
        $display("%0d results checked, %0d of them matches", n_results, n_hits);
        if (err_count == 0) begin
            $display("first_match_substring_search_unit_test: clean");
        end else begin
            $display("first_match_substring_search_unit_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
